// ===== sv/psem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plate strip element matrices: shared package
// Types, coefficient tables and constants used across the element matrix unit.
// ----------------------------------------------------------------------------
package psem_pkg;

  // Matrix identifiers on the result channel.
  localparam logic [1:0] MAT_K4 = 2'd0;
  localparam logic [1:0] MAT_K0 = 2'd1;
  localparam logic [1:0] MAT_K2 = 2'd2;

  // Last row number of an element (three matrices of four rows).
  localparam logic [3:0] ROW_LAST = 4'd11;

  // Register stages from a lane command to its registered entry.
  localparam int LANE_LAT = 69;

  // Width of the wide dividend and divisor words.
  localparam int BIG_W = 256;

  localparam logic [63:0] ENTRY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ENTRY_MIN = 64'h8000_0000_0000_0000;

  typedef logic signed [8:0] coef_t;

  localparam coef_t MAT_A [4][4] = '{
    '{9'sd156, 9'sd22, 9'sd54, -9'sd13}, '{9'sd22, 9'sd4, 9'sd13, -9'sd3},
    '{9'sd54, 9'sd13, 9'sd156, -9'sd22}, '{-9'sd13, -9'sd3, -9'sd22, 9'sd4}};
  localparam coef_t MAT_B [4][4] = '{
    '{9'sd6, 9'sd3, -9'sd6, 9'sd3}, '{9'sd3, 9'sd2, -9'sd3, 9'sd1},
    '{-9'sd6, -9'sd3, 9'sd6, -9'sd3}, '{9'sd3, 9'sd1, -9'sd3, 9'sd2}};
  localparam coef_t MAT_C [4][4] = '{
    '{-9'sd36, -9'sd33, 9'sd36, -9'sd3}, '{-9'sd3, -9'sd4, 9'sd3, 9'sd1},
    '{9'sd36, 9'sd3, -9'sd36, 9'sd33}, '{-9'sd3, 9'sd1, 9'sd3, -9'sd4}};
  localparam coef_t MAT_G [4][4] = '{
    '{9'sd36, 9'sd3, -9'sd36, 9'sd3}, '{9'sd3, 9'sd4, -9'sd3, -9'sd1},
    '{-9'sd36, -9'sd3, 9'sd36, -9'sd3}, '{9'sd3, -9'sd1, -9'sd3, 9'sd4}};

  // Per-element products prepared ahead of the row sequencer.
  typedef struct packed {
    logic [127:0] et3;
    logic [159:0] et3h;
    logic [191:0] et3h2;
    logic [223:0] et3h3;
    logic [30:0]  q;
    logic [62:0]  qh;
    logic [94:0]  qh2;
    logic [126:0] qh3;
    logic [14:0]  nr;
    logic         hz;
  } prep_t;

  // Work for one entry lane.
  typedef struct packed {
    logic         neg;
    logic         hz;
    logic [22:0]  mag;
    logic [223:0] x;
    logic [126:0] y;
    logic [12:0]  dc;
    logic [7:0]   nsh;
    logic [7:0]   dsh;
  } lane_cmd_t;

  // Row tag that travels beside the lanes.
  typedef struct packed {
    logic [1:0] mid;
    logic [1:0] row;
    logic       hz;
    logic       last;
  } tag_t;

endpackage

// ===== sv/psem_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plate strip element matrices: channel interfaces
// Valid/ready channels for element transactions and matrix row transactions.
// ----------------------------------------------------------------------------
interface psem_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_length;
  logic [31:0] youngs_modulus;
  logic [14:0] poisson_ratio;

  modport source(output valid, output element_length, output youngs_modulus,
                 output poisson_ratio, input ready);
  modport sink(input valid, input element_length, input youngs_modulus,
               input poisson_ratio, output ready);
endinterface

interface psem_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         matrix_id;
  logic [1:0]         row_index;
  logic signed [63:0] entry_col0;
  logic signed [63:0] entry_col1;
  logic signed [63:0] entry_col2;
  logic signed [63:0] entry_col3;
  logic               saturated;
  logic               length_error;
  logic               last_row;

  modport source(output valid, output matrix_id, output row_index, output entry_col0,
                 output entry_col1, output entry_col2, output entry_col3,
                 output saturated, output length_error, output last_row, input ready);
  modport sink(input valid, input matrix_id, input row_index, input entry_col0,
               input entry_col1, input entry_col2, input entry_col3,
               input saturated, input length_error, input last_row, output ready);
endinterface

// ===== sv/psem_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limb multiplier
// Multiplies a multi-limb word by a narrow operand in two stages: one 32-bit
// limb product per limb, then a single wide add of the even and odd partials.
// ----------------------------------------------------------------------------
module psem_mul #(
  parameter int NL = 2,
  parameter int BW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [32*NL-1:0]     a,
  input  logic [BW-1:0]        b,
  output logic [32*NL+BW-1:0]  p
);

  localparam int PW = 32 * NL + BW;

  logic [32+BW-1:0] pp [NL];
  logic [PW-1:0]    ev;
  logic [PW-1:0]    od;

  // Limb products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        pp[i] <= a[32*i +: 32] * b;
      end
    end
  end

  // Even and odd partials do not overlap among themselves.
  always_comb begin
    ev = '0;
    od = '0;
    for (int i = 0; i < NL; i += 2) begin
      ev[32*i +: 32+BW] = pp[i];
    end
    for (int i = 1; i < NL; i += 2) begin
      od[32*(i-1) +: 32+BW] = pp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= ev + (od << 32);
    end
  end

endmodule

// ===== sv/psem_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Element preparation pipeline
// Forms E*t^3*h^k and q*h^k for one element, q = 2^30 - nu^2, in twelve
// register stages built from chained limb multipliers.
// ----------------------------------------------------------------------------
module psem_prep (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     h,
  input  logic [31:0]     e,
  input  logic [14:0]     nr,
  input  logic [31:0]     t,
  output logic            out_valid,
  output psem_pkg::prep_t out
);

  typedef struct packed {
    logic [31:0]  h;
    logic [31:0]  e;
    logic [31:0]  t;
    logic [14:0]  nr;
    logic         hz;
    logic [30:0]  q;
    logic [127:0] et3;
    logic [159:0] et3h;
    logic [191:0] et3h2;
    logic [62:0]  qh;
    logic [94:0]  qh2;
    logic [126:0] qh3;
  } side_t;

  side_t        side    [0:12];
  side_t        side_in [1:12];
  side_t        s0_new;
  logic [12:0]  vld;
  logic         v0_next;
  logic         load;

  logic [46:0]  nr2_p;
  logic [63:0]  t2;
  logic [95:0]  t3;
  logic [127:0] et3;
  logic [63:0]  qh_p;
  logic [159:0] et3h;
  logic [95:0]  qh2_p;
  logic [191:0] et3h2;
  logic [127:0] qh3_p;
  logic [223:0] et3h3;

  assign in_ready  = adv || !vld[0];
  assign load      = in_valid && in_ready;
  assign out_valid = vld[12];
  assign v0_next   = load ? 1'b1 : (adv ? 1'b0 : vld[0]);

  // Capture of a new element.
  always_comb begin
    s0_new    = '0;
    s0_new.h  = h;
    s0_new.e  = e;
    s0_new.t  = t;
    s0_new.nr = nr;
    s0_new.hz = (h == 32'd0);
  end

  // Multiplier chain.
  psem_mul #(.NL(1), .BW(15)) u_nr2 (.clk(clk), .en(adv),
    .a({17'd0, side[0].nr}), .b(side[0].nr), .p(nr2_p));
  psem_mul #(.NL(1), .BW(32)) u_t2 (.clk(clk), .en(adv),
    .a(side[0].t), .b(side[0].t), .p(t2));
  psem_mul #(.NL(2), .BW(32)) u_t3 (.clk(clk), .en(adv),
    .a(t2), .b(side[2].t), .p(t3));
  psem_mul #(.NL(3), .BW(32)) u_et3 (.clk(clk), .en(adv),
    .a(t3), .b(side[4].e), .p(et3));
  psem_mul #(.NL(1), .BW(32)) u_qh (.clk(clk), .en(adv),
    .a({1'b0, side[4].q}), .b(side[4].h), .p(qh_p));
  psem_mul #(.NL(4), .BW(32)) u_et3h (.clk(clk), .en(adv),
    .a(et3), .b(side[6].h), .p(et3h));
  psem_mul #(.NL(2), .BW(32)) u_qh2 (.clk(clk), .en(adv),
    .a({1'b0, qh_p[62:0]}), .b(side[6].h), .p(qh2_p));
  psem_mul #(.NL(5), .BW(32)) u_et3h2 (.clk(clk), .en(adv),
    .a(et3h), .b(side[8].h), .p(et3h2));
  psem_mul #(.NL(3), .BW(32)) u_qh3 (.clk(clk), .en(adv),
    .a({1'b0, qh2_p[94:0]}), .b(side[8].h), .p(qh3_p));
  psem_mul #(.NL(6), .BW(32)) u_et3h3 (.clk(clk), .en(adv),
    .a(et3h2), .b(side[10].h), .p(et3h3));

  // Side data moves one stage per advance and collects the products.
  always_comb begin
    for (int k = 1; k <= 12; k++) begin
      side_in[k] = side[k-1];
    end
    side_in[3].q      = 31'h4000_0000 - {1'b0, nr2_p[29:0]};
    side_in[7].et3    = et3;
    side_in[7].qh     = qh_p[62:0];
    side_in[9].et3h   = et3h;
    side_in[9].qh2    = qh2_p[94:0];
    side_in[11].et3h2 = et3h2;
    side_in[11].qh3   = qh3_p[126:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[11:0], v0_next};
    end else begin
      vld <= {vld[12:1], v0_next};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      side[0] <= s0_new;
    end
    if (adv) begin
      for (int k = 1; k <= 12; k++) begin
        side[k] <= side_in[k];
      end
    end
  end

  // Results of the last stage.
  always_comb begin
    out.et3   = side[12].et3;
    out.et3h  = side[12].et3h;
    out.et3h2 = side[12].et3h2;
    out.et3h3 = et3h3;
    out.q     = side[12].q;
    out.qh    = side[12].qh;
    out.qh2   = side[12].qh2;
    out.qh3   = side[12].qh3;
    out.nr    = side[12].nr;
    out.hz    = side[12].hz;
  end

endmodule

// ===== sv/psem_rows.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row sequencer
// Holds one prepared element and issues its twelve matrix rows, one row per
// cycle while enabled, as four entry commands and a row tag.
// ----------------------------------------------------------------------------
module psem_rows #(
  parameter int FRAC_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  psem_pkg::prep_t       it,
  output logic                  take,
  output psem_pkg::lane_cmd_t   cmd [4],
  output psem_pkg::tag_t        tag,
  output logic                  tag_valid
);

  psem_pkg::prep_t     item;
  logic                busy;
  logic [3:0]          k;
  psem_pkg::lane_cmd_t cmd_next [4];
  psem_pkg::tag_t      tag_next;

  // Entry description for one column of the current row.
  function automatic psem_pkg::lane_cmd_t build_cmd(input logic [1:0] mid,
                                                   input logic [1:0] r,
                                                   input logic [1:0] c,
                                                   input psem_pkg::prep_t p);
    psem_pkg::lane_cmd_t cm;
    int                  a;
    int                  nsh;
    int                  dsh;
    int                  s;
    psem_pkg::coef_t     m;
    logic [8:0]          mabs;
    logic signed [9:0]   cs;
    logic signed [15:0]  nr_s;
    logic signed [16:0]  nd_s;
    logic signed [27:0]  t1;
    logic signed [27:0]  t2;
    logic signed [27:0]  w;
    logic [27:0]         wabs;
    cm   = '0;
    cm.hz = p.hz;
    a    = int'(r[0]) + int'(c[0]);
    nsh  = 0;
    dsh  = 0;
    case (mid)
      psem_pkg::MAT_K4: begin
        m      = psem_pkg::MAT_A[r][c];
        mabs   = m[8] ? 9'(-m) : 9'(m);
        cm.neg = m[8];
        cm.mag = {14'd0, mabs};
        cm.x   = (a == 0) ? 224'(p.et3h) : (a == 1) ? 224'(p.et3h2) : p.et3h3;
        cm.y   = 127'(p.q);
        cm.dc  = 13'd5040;
        nsh    = 30 + FRAC_BITS;
        dsh    = FRAC_BITS * (4 + a);
      end
      psem_pkg::MAT_K0: begin
        m      = psem_pkg::MAT_B[r][c];
        mabs   = m[8] ? 9'(-m) : 9'(m);
        cm.neg = !m[8] && (m != 9'sd0);
        cm.mag = {13'd0, mabs, 1'b0};
        cm.x   = 224'(p.et3);
        cm.y   = (a == 0) ? p.qh3 : (a == 1) ? 127'(p.qh2) : 127'(p.qh);
        cm.dc  = 13'd12;
        nsh    = 30 + FRAC_BITS * (4 - a);
        dsh    = 3 * FRAC_BITS;
      end
      default: begin
        // Mixed term: nu*(C + C^T) + 2*(1 - nu)*G on a 2^15 scale.
        cs     = psem_pkg::MAT_C[r][c] + psem_pkg::MAT_C[c][r];
        nr_s   = $signed({1'b0, p.nr});
        nd_s   = $signed({1'b0, 16'(17'd32768 - {2'b0, p.nr})});
        t1     = nr_s * cs;
        t2     = nd_s * psem_pkg::MAT_G[r][c];
        w      = t1 + (t2 <<< 1);
        wabs   = w[27] ? 28'(-w) : 28'(w);
        cm.neg = !w[27] && (w != 28'sd0);
        cm.mag = wabs[22:0];
        cm.dc  = 13'd360;
        if (a == 0) begin
          cm.x = 224'(p.et3);
          cm.y = 127'(p.qh);
          nsh  = 30 + 2 * FRAC_BITS;
          dsh  = 15 + 3 * FRAC_BITS;
        end else begin
          cm.x = (a == 1) ? 224'(p.et3) : 224'(p.et3h);
          cm.y = 127'(p.q);
          nsh  = 30 + FRAC_BITS;
          dsh  = 15 + FRAC_BITS * (2 + a);
        end
      end
    endcase
    // Only the net power of two matters; apply it to one side.
    s      = nsh - dsh;
    cm.nsh = (s > 0) ? 8'(s) : 8'd0;
    cm.dsh = (s < 0) ? 8'(-s) : 8'd0;
    return cm;
  endfunction

  assign take = en && (!busy || (k == psem_pkg::ROW_LAST));

  // Commands for the four columns of the current row.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cmd_next[c] = build_cmd(k[3:2], k[1:0], 2'(c), item);
    end
    tag_next.mid  = k[3:2];
    tag_next.row  = k[1:0];
    tag_next.hz   = item.hz;
    tag_next.last = (k == psem_pkg::ROW_LAST);
  end

  // Row counter and element hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k         <= '0;
      tag_valid <= 1'b0;
    end else if (en) begin
      tag_valid <= busy;
      if (busy && (k != psem_pkg::ROW_LAST)) begin
        k <= k + 4'd1;
      end else begin
        busy <= in_valid;
        k    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd <= cmd_next;
      tag <= tag_next;
    end
    if (take && in_valid) begin
      item <= it;
    end
  end

endmodule

// ===== sv/psem_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entry lane
// Forms one matrix entry: numerator and denominator products, a pipelined
// restoring divider one quotient bit per stage, rounding and saturation.
// ----------------------------------------------------------------------------
module psem_lane (
  input  logic                clk,
  input  logic                en,
  input  psem_pkg::lane_cmd_t cmd,
  output logic [63:0]         value,
  output logic                sat
);

  localparam int W = psem_pkg::BIG_W;

  typedef struct packed {
    logic       neg;
    logic       hz;
    logic [7:0] nsh;
    logic [7:0] dsh;
  } ctl_t;

  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] dr;
    logic [63:0]  quo;
    logic         neg;
    logic         hz;
    logic         ovf;
  } div_t;

  logic [246:0] nprod;
  logic [140:0] dprod;
  ctl_t         c1;
  ctl_t         c2;
  ctl_t         c3;
  logic [W-1:0] num;
  logic [W-1:0] den;
  div_t         div [0:64];

  // Numerator and denominator products.
  psem_mul #(.NL(7), .BW(23)) u_nmul (.clk(clk), .en(en),
    .a(cmd.x), .b(cmd.mag), .p(nprod));
  psem_mul #(.NL(4), .BW(13)) u_dmul (.clk(clk), .en(en),
    .a({1'b0, cmd.y}), .b(cmd.dc), .p(dprod));

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= '{neg: cmd.neg, hz: cmd.hz, nsh: cmd.nsh, dsh: cmd.dsh};
      c2 <= c1;
    end
  end

  // Rounding to nearest: (2N + D) / 2D with the scale shifts applied.
  always_ff @(posedge clk) begin
    if (en) begin
      num <= ((W'(nprod) << 1) << c2.nsh) + (W'(dprod) << c2.dsh);
      den <= W'(dprod) << ({1'b0, c2.dsh} + 9'd1);
      c3  <= c2;
    end
  end

  // A quotient of 2^64 or more saturates.
  always_ff @(posedge clk) begin
    if (en) begin
      div[0].rem <= num;
      div[0].dr  <= den;
      div[0].quo <= '0;
      div[0].neg <= c3.neg;
      div[0].hz  <= c3.hz;
      div[0].ovf <= ({64'd0, num} >= {den, 64'd0});
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < 64; j++) begin : g_div
    logic [W+63:0] dsub;
    logic          ge;
    div_t          nxt;
    always_comb begin
      dsub    = {64'd0, div[j].dr} << (63 - j);
      ge      = ({64'd0, div[j].rem} >= dsub);
      nxt     = div[j];
      nxt.rem = ge ? (div[j].rem - dsub[W-1:0]) : div[j].rem;
      nxt.quo[63-j] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        div[j+1] <= nxt;
      end
    end
  end

  // Sign, clipping and zero length.
  always_ff @(posedge clk) begin
    if (en) begin
      if (div[64].hz) begin
        value <= '0;
        sat   <= 1'b0;
      end else if (div[64].ovf) begin
        value <= div[64].neg ? psem_pkg::ENTRY_MIN : psem_pkg::ENTRY_MAX;
        sat   <= 1'b1;
      end else if (div[64].neg) begin
        if (div[64].quo > psem_pkg::ENTRY_MIN) begin
          value <= psem_pkg::ENTRY_MIN;
          sat   <= 1'b1;
        end else begin
          value <= ~div[64].quo + 64'd1;
          sat   <= 1'b0;
        end
      end else if (div[64].quo[63]) begin
        value <= psem_pkg::ENTRY_MAX;
        sat   <= 1'b1;
      end else begin
        value <= div[64].quo;
        sat   <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/plate_strip_element_matrices_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one row per cycle when the result channel does not stall; the row
// sequencer issues one row at a time, each row going through four 69-stage entry lanes.
// Reset: synchronous; empties every stage and sets the plate thickness to 1.0.
// No memories, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// Plate strip element matrices unit
// Emits the K4, K0 and K2 Hermite element matrices of one element, row by row.
// ----------------------------------------------------------------------------
module plate_strip_element_matrices_unit #(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  psem_in_if.sink     items,
  psem_out_if.source  results
);

  localparam int L = psem_pkg::LANE_LAT;
  localparam logic [31:0] T_RESET = 32'(64'd1 << FRAC_BITS);

  logic                en;
  logic [31:0]         thickness;
  logic                prep_adv;
  logic                prep_valid;
  psem_pkg::prep_t     prep_out;
  logic                take;
  psem_pkg::lane_cmd_t cmd [4];
  psem_pkg::tag_t      tag;
  logic                tag_valid;
  logic [63:0]         lane_value [4];
  logic [3:0]          lane_sat;
  logic [L:1]          tvld;
  psem_pkg::tag_t      tags [1:L];

  // The whole row pipeline moves when the output register can be written.
  assign en       = !results.valid || results.ready;
  assign prep_adv = !prep_valid || take;

  // Thickness register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thickness <= T_RESET;
    end else if (cfg_we) begin
      thickness <= cfg_wdata;
    end
  end

  psem_prep u_prep (
    .clk(clk), .rst(rst), .adv(prep_adv),
    .in_valid(items.valid), .in_ready(items.ready),
    .h(items.element_length), .e(items.youngs_modulus), .nr(items.poisson_ratio),
    .t(thickness), .out_valid(prep_valid), .out(prep_out)
  );

  psem_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
    .clk(clk), .rst(rst), .en(en), .in_valid(prep_valid), .it(prep_out),
    .take(take), .cmd(cmd), .tag(tag), .tag_valid(tag_valid)
  );

  for (genvar c = 0; c < 4; c++) begin : g_lane
    psem_lane u_lane (
      .clk(clk), .en(en), .cmd(cmd[c]), .value(lane_value[c]), .sat(lane_sat[c])
    );
  end

  // Row tags follow the lanes stage for stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      tvld <= '0;
    end else if (en) begin
      tvld <= {tvld[L-1:1], tag_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tags[1] <= tag;
      for (int s = 2; s <= L; s++) begin
        tags[s] <= tags[s-1];
      end
    end
  end

  // Result transaction.
  assign results.valid        = tvld[L];
  assign results.matrix_id    = tags[L].mid;
  assign results.row_index    = tags[L].row;
  assign results.entry_col0   = lane_value[0];
  assign results.entry_col1   = lane_value[1];
  assign results.entry_col2   = lane_value[2];
  assign results.entry_col3   = lane_value[3];
  assign results.saturated    = |lane_sat;
  assign results.length_error = tags[L].hz;
  assign results.last_row     = tags[L].last;

  // A zero-length element gives zero rows that never clip.
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.length_error |->
      results.entry_col0 == 64'sd0 && results.entry_col1 == 64'sd0 &&
      results.entry_col2 == 64'sd0 && results.entry_col3 == 64'sd0 && !results.saturated)
    else $error("zero-length row carries non-zero entries");

  // The final row of an element is the last row of K2.
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.last_row |->
      results.matrix_id == psem_pkg::MAT_K2 && results.row_index == 2'd3)
    else $error("last row flag on the wrong row");

  // The first K4 diagonal entry is never negative.
  a_k4_diag: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.matrix_id == psem_pkg::MAT_K4 && results.row_index == 2'd0
      |-> !results.entry_col0[63])
    else $error("negative K4 diagonal entry");

  // The first K0 diagonal entry is never positive.
  a_k0_diag: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.matrix_id == psem_pkg::MAT_K0 && results.row_index == 2'd0
      |-> results.entry_col0[63] || results.entry_col0 == 64'sd0)
    else $error("positive K0 diagonal entry");

endmodule

// ===== tb/sv/psem_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plate strip element matrices: testbench interface note
// The channel interfaces come from the RTL interface file; this file only
// carries the record types that the testbench uses for one matrix row and one element.
// ----------------------------------------------------------------------------
package psem_tb_pkg;

  // One matrix row as it leaves the unit.
  typedef struct packed {
    logic [1:0]         matrix_id;
    logic [1:0]         row_index;
    logic signed [63:0] entry_col0;
    logic signed [63:0] entry_col1;
    logic signed [63:0] entry_col2;
    logic signed [63:0] entry_col3;
    logic               saturated;
    logic               length_error;
    logic               last_row;
  } matrix_row_t;

  // One element transaction.
  typedef struct packed {
    logic [31:0] element_length;
    logic [31:0] youngs_modulus;
    logic [14:0] poisson_ratio;
  } element_t;

endpackage

// ===== tb/sv/plate_strip_element_matrices_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plate strip element matrices unit testbench
// Drives element transactions through the unit under several plate thickness
// settings, predicts the twelve rows of each element with exact wide integer
// arithmetic and checks every row transaction against the prediction in order.
// ----------------------------------------------------------------------------
module plate_strip_element_matrices_unit_tb;

  localparam int FRAC = 24;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic [399:0] wide_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  psem_in_if  items ();
  psem_out_if results ();

  plate_strip_element_matrices_unit #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .items(items.sink), .results(results.source)
  );

  always #4 clk = ~clk;

  psem_tb_pkg::element_t    pending_elements[$];
  psem_tb_pkg::matrix_row_t expected_rows[$];
  logic [31:0] thickness = 32'h0100_0000;
  bit          no_idle = 1'b0;
  int          mismatches = 0;
  int          rows_checked = 0;
  int          elements_sent = 0;
  int          stall_cycles = 0;

  // Rounded and saturated entry: mag*E*t^3*h^hn*2^nsh / (dc*q*h^hd*2^dsh).
  function automatic logic [64:0] entry_value(bit neg, logic [63:0] mag, logic [31:0] e,
      logic [31:0] t, logic [31:0] h, logic [30:0] q, int hn, int nsh, int dc,
      int hd, int dsh);
    wide_t num, den, quo;
    num = wide_t'(mag) * wide_t'(e) * wide_t'(t) * wide_t'(t) * wide_t'(t);
    for (int i = 0; i < hn; i++) num = num * wide_t'(h);
    num = num << nsh;
    den = wide_t'(dc) * wide_t'(q);
    for (int i = 0; i < hd; i++) den = den * wide_t'(h);
    den = den << dsh;
    quo = ((num << 1) + den) / (den << 1);
    if (neg) begin
      if (quo > wide_t'(64'h8000_0000_0000_0000)) return {1'b1, psem_pkg::ENTRY_MIN};
      return {1'b0, -quo[63:0]};
    end
    if (quo > wide_t'(psem_pkg::ENTRY_MAX)) return {1'b1, psem_pkg::ENTRY_MAX};
    return {1'b0, quo[63:0]};
  endfunction

  // Predict the twelve rows of one element.
  task automatic predict_element_rows(psem_tb_pkg::element_t el);
    logic [31:0] h;
    logic [30:0] q;
    logic [64:0] v;
    logic [63:0] col [4];
    int          nr, a, m, w;
    bit          sat;
    psem_tb_pkg::matrix_row_t row;
    h  = el.element_length;
    nr = el.poisson_ratio;
    q  = 31'(32'h4000_0000 - nr * nr);
    for (int k = 0; k < 12; k++) begin
      sat = 1'b0;
      for (int c = 0; c < 4; c++) begin
        a = (k % 4) % 2 + c % 2;
        v = '0;
        if (h != 0) begin
          case (k / 4)
            0: begin
              m = psem_pkg::MAT_A[k % 4][c];
              v = entry_value(m < 0, m < 0 ? -m : m, el.youngs_modulus, thickness, h, q,
                              1 + a, 30 + FRAC, 5040, 0, FRAC * (4 + a));
            end
            1: begin
              m = psem_pkg::MAT_B[k % 4][c];
              v = entry_value(m > 0, 2 * (m < 0 ? -m : m), el.youngs_modulus, thickness,
                              h, q, 0, 30 + FRAC * (4 - a), 12, 3 - a, 3 * FRAC);
            end
            default: begin
              w = nr * (psem_pkg::MAT_C[k % 4][c] + psem_pkg::MAT_C[c][k % 4])
                  + 2 * (32768 - nr) * psem_pkg::MAT_G[k % 4][c];
              if (a == 0)
                v = entry_value(w > 0, w < 0 ? -w : w, el.youngs_modulus, thickness, h, q,
                                0, 30 + 2 * FRAC, 360, 1, 15 + 3 * FRAC);
              else
                v = entry_value(w > 0, w < 0 ? -w : w, el.youngs_modulus, thickness, h, q,
                                a - 1, 30 + FRAC, 360, 0, 15 + FRAC * (2 + a));
            end
          endcase
        end
        sat |= v[64];
        col[c] = v[63:0];
      end
      row.matrix_id    = 2'(k / 4);
      row.row_index    = 2'(k % 4);
      row.entry_col0   = col[0];
      row.entry_col1   = col[1];
      row.entry_col2   = col[2];
      row.entry_col3   = col[3];
      row.saturated    = sat;
      row.length_error = (h == 0);
      row.last_row     = (k == int'(psem_pkg::ROW_LAST));
      expected_rows = {expected_rows, row};
    end
  endtask

  // Appends one element to the queue of pending elements.
  task automatic queue_element(input psem_tb_pkg::element_t el);
    pending_elements = {pending_elements, el};
  endtask

  // Element driver: takes the next pending element, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      items.valid <= 1'b0;
    end else if (!items.valid || items.ready) begin
      if (pending_elements.size() > 0 && (no_idle || $urandom_range(99) >= 26)) begin
        items.element_length <= pending_elements[0].element_length;
        items.youngs_modulus <= pending_elements[0].youngs_modulus;
        items.poisson_ratio  <= pending_elements[0].poisson_ratio;
        items.valid          <= 1'b1;
        void'(pending_elements.pop_front());
      end else begin
        items.valid <= 1'b0;
      end
    end
  end

  initial begin
    items.element_length = '0;
    items.youngs_modulus = '0;
    items.poisson_ratio  = '0;
    items.valid          = 1'b0;
    results.ready        = 1'b0;
  end

  // Result sink back-pressure.
  always @(posedge clk) begin
    results.ready <= rst ? 1'b0 : (no_idle || $urandom_range(99) >= 26);
  end

  // Monitor: predicts on each element transaction, checks each row transaction.
  always @(posedge clk) begin
    psem_tb_pkg::matrix_row_t got, want;
    if (!rst) begin
      if (items.valid && items.ready) begin
        predict_element_rows({items.element_length, items.youngs_modulus,
                              items.poisson_ratio});
        elements_sent++;
      end
      if (results.valid && results.ready) begin
        got = {results.matrix_id, results.row_index, results.entry_col0,
               results.entry_col1, results.entry_col2, results.entry_col3,
               results.saturated, results.length_error, results.last_row};
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected row transaction: mat %0d row %0d",
                                         got.matrix_id, got.row_index);
        end else begin
          want = expected_rows.pop_front();
          rows_checked++;
          if (got.matrix_id !== want.matrix_id || got.row_index !== want.row_index ||
              got.entry_col0 !== want.entry_col0 || got.entry_col1 !== want.entry_col1 ||
              got.entry_col2 !== want.entry_col2 || got.entry_col3 !== want.entry_col3 ||
              got.saturated !== want.saturated || got.length_error !== want.length_error ||
              got.last_row !== want.last_row) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected mat %0d row %0d %h %h %h %h sat %b err %b last %b",
                       want.matrix_id, want.row_index, want.entry_col0, want.entry_col1,
                       want.entry_col2, want.entry_col3, want.saturated,
                       want.length_error, want.last_row);
              $display("          actual   mat %0d row %0d %h %h %h %h sat %b err %b last %b",
                       got.matrix_id, got.row_index, got.entry_col0, got.entry_col1,
                       got.entry_col2, got.entry_col3, got.saturated,
                       got.length_error, got.last_row);
            end
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction while work is outstanding.
  always @(posedge clk) begin
    if ((items.valid && items.ready) || (results.valid && results.ready) ||
        (pending_elements.size() == 0 && !items.valid && expected_rows.size() == 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d rows outstanding", expected_rows.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic psem_tb_pkg::element_t random_element();
    psem_tb_pkg::element_t el;
    case ($urandom_range(3))
      0: begin
        el.element_length = $urandom;
        el.youngs_modulus = $urandom;
        el.poisson_ratio  = 15'($urandom);
      end
      default: begin
        // Moderate, physically sensible elements.
        el.element_length = $urandom_range(32'h0800_0000, 32'h0000_4000);
        el.youngs_modulus = $urandom_range(300000, 1);
        el.poisson_ratio  = 15'($urandom_range(16384));
      end
    endcase
    return el;
  endfunction

  task automatic wait_for_drain();
    while (pending_elements.size() > 0 || items.valid || expected_rows.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Stimulus: directed elements, then random phases under several thicknesses.
  initial begin
    logic [31:0] thick_set [5];
    thick_set = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0040_0000, 32'h0000_0000};
    thick_set[4] = $urandom_range(32'h0400_0000, 32'h0000_1000);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero length, extreme fields, ratio beyond one half.
    queue_element('{32'h0, 32'd200000, 15'd9830});
    queue_element('{32'h0100_0000, 32'd200000, 15'd9830});
    queue_element('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'd16384});
    queue_element('{32'h0000_0001, 32'hFFFF_FFFF, 15'd0});
    queue_element('{32'h0000_0001, 32'd1, 15'h7FFF});
    queue_element('{32'h0100_0000, 32'd0, 15'd5000});
    queue_element('{32'h0080_0000, 32'd70000, 15'h7FFF});
    queue_element('{32'hFFFF_FFFF, 32'd0, 15'd0});
    queue_element('{32'h0000_0000, 32'hFFFF_FFFF, 15'h7FFF});
    queue_element('{32'h0200_0000, 32'd1, 15'd16384});
    wait_for_drain();

    // Random phases, each under its own thickness, with the block idle on writes.
    for (int p = 0; p < 5; p++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= thick_set[p];
      @(posedge clk);
      cfg_we    <= 1'b0;
      thickness = thick_set[p];
      @(posedge clk);
      no_idle = (p == 2);
      for (int i = 0; i < 44; i++) queue_element(random_element());
      wait_for_drain();
      no_idle = 1'b0;
    end

    $display("Checked %0d rows from %0d elements over six thickness settings,",
             rows_checked, elements_sent);
    $display("including zero length, saturating and full-range random elements.");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
